// ===== sv/afra_pkg.sv =====
package afra_pkg;

  localparam int NODES     = 256;
  localparam int NODE_W    = $clog2(NODES);
  localparam int LINK_W    = NODE_W + 1;
  localparam int ADDR_W    = 32;
  localparam int ALIGN_W   = 21;
  localparam int DEF_ALIGN = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NODES);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_FIT      = 3'd1,
    ST_BAD_REQ     = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_UNKNOWN     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_START = 2'd0,
    REG_R0_END   = 2'd1,
    REG_R1_START = 2'd2,
    REG_R1_END   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              free;
    logic [LINK_W-1:0] link;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_BUILD0,
    S_BUILD1,
    S_WINIT,
    S_WALK,
    S_AEV1,
    S_AEV2,
    S_AFIT,
    S_AFIT2,
    S_POP,
    S_POPW,
    S_PADW1,
    S_PADW2,
    S_TAILCHK,
    S_TAILW1,
    S_TAILW2,
    S_REV,
    S_MFRD,
    S_MFEV,
    S_MFEND,
    S_DONE
  } state_e;

endpackage

// ===== sv/afra_node_mem.sv =====
module afra_node_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [afra_pkg::NODE_W-1:0]  waddr_i,
  input  afra_pkg::node_t              wdata_i,
  input  logic [afra_pkg::NODE_W-1:0]  raddr_i,
  output afra_pkg::node_t              rdata_o
);
  import afra_pkg::*;

  node_t mem_q [NODES];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/aligned_first_fit_region_allocator_unit.sv =====
// Check steps through S_CHECK to S_DONE, where done_o strobes. Allocate walks the
// table block by block, evaluating free blocks further than allocated ones, and may
// split the fitting block; release walks the blocks and then merges neighbours. The
// first allocate or release after reset first builds the tables. The node memory gives
// one read per cycle; one command at a time, busy through the done_o cycle.
// Reset clears control state and the region registers; no clearing pass.
module aligned_first_fit_region_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  output logic                           done_o,
  input  logic [1:0]                     cmd_i,
  input  logic [31:0]                    request_size_i,
  input  logic [20:0]                    request_alignment_i,
  input  logic [31:0]                    target_address_i,
  input  logic [31:0]                    range_length_i,
  output logic [31:0]                    granted_address_o,
  output logic [2:0]                     status_o,
  output logic                           range_safe_o,
  input  logic                           cfg_we_i,
  input  logic [afra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i
);
  import afra_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] r0s_q, r0e_q, r1s_q, r1e_q;

  cmd_e              cmd_q, cmd_d;
  logic [ADDR_W-1:0] size_q, size_d, amask_q, amask_d, addr_q, addr_d, rlen_q, rlen_d;
  logic [ADDR_W-1:0] gnt_q, gnt_d;
  status_e           status_q, status_d;
  logic              safe_q, safe_d;

  logic [LINK_W-1:0] node_q, node_d;
  logic              region_q, region_d;
  node_t             cur_q, cur_d, prev_q, prev_d;
  logic [NODE_W-1:0] cur_idx_q, cur_idx_d, prev_idx_q, prev_idx_d, new_q, new_d;
  logic              prev_v_q, prev_v_d;
  logic [ADDR_W-1:0] aligned_q, aligned_d, pad_q, pad_d, rem_q, rem_d;
  logic              too_big_q, too_big_d, pop_tail_q, pop_tail_d;
  logic [LINK_W-1:0] fresh_q, fresh_d, sp_q, sp_d;
  logic              built_q, built_d;
  logic [LINK_W-1:0] first0_q, first0_d, first1_q, first1_d;

  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr, mem_raddr;
  node_t             mem_wdata, mem_rdata;

  logic              push_we;
  logic [NODE_W-1:0] push_idx;
  logic [NODE_W-1:0] stack_mem [NODES];
  logic [NODE_W-1:0] stack_rd_q;
  logic [LINK_W-1:0] sp_m1;

  logic              rv0, rv1, in0, in1, avail;
  logic [LINK_W-1:0] walk0, walk1;
  logic [ADDR_W:0]   chk_sum;
  logic              chk_ok;

  function automatic logic [ADDR_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
    int unsigned       p;
    logic [ALIGN_W:0]  pw;
    logic [ADDR_W-1:0] m;
    p  = 0;
    pw = '0;
    m  = ADDR_W'(DEF_ALIGN - 1);
    for (int i = 0; i < ALIGN_W; i++) begin
      if (a[i]) begin
        p = i;
      end
    end
    if (a == '0) begin
      m = ADDR_W'(DEF_ALIGN - 1);
    end else if ((a & (a - ALIGN_W'(1))) == '0) begin
      m = ADDR_W'(a - ALIGN_W'(1));
    end else begin
      pw = (ALIGN_W + 1)'(1) << (p + 1);
      if (pw < (ALIGN_W + 1)'(DEF_ALIGN)) begin
        m = ADDR_W'(DEF_ALIGN - 1);
      end else begin
        m = ADDR_W'(pw - (ALIGN_W + 1)'(1));
      end
    end
    return m;
  endfunction

  afra_node_mem u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // recycled node stack
  assign sp_m1 = sp_q - LINK_W'(1);
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stack_mem[sp_q[NODE_W-1:0]] <= push_idx;
    end
    stack_rd_q <= stack_mem[sp_m1[NODE_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0s_q <= '0;
      r0e_q <= '0;
      r1s_q <= '0;
      r1e_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_R0_START: r0s_q <= cfg_wdata_i;
        REG_R0_END:   r0e_q <= cfg_wdata_i;
        REG_R1_START: r1s_q <= cfg_wdata_i;
        REG_R1_END:   r1e_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rv0   = r0s_q < r0e_q;
  assign rv1   = r1s_q < r1e_q;
  assign in0   = (addr_q >= r0s_q) && (addr_q < r0e_q);
  assign in1   = (addr_q >= r1s_q) && (addr_q < r1e_q);
  assign walk0 = (rv0 && ((cmd_q == CMD_ALLOC) || in0)) ? first0_q : NONE_LINK;
  assign walk1 = (rv1 && ((cmd_q == CMD_ALLOC) || in1)) ? first1_q : NONE_LINK;
  assign avail = (fresh_q != '0) || (sp_q != '0);

  assign chk_sum = {1'b0, addr_q} + {1'b0, rlen_q};
  assign chk_ok  = (addr_q != '0) && (rlen_q != '0) && !chk_sum[ADDR_W] &&
                   ((addr_q & ADDR_W'(DEF_ALIGN - 1)) == '0) &&
                   ((rv0 && (addr_q >= r0s_q) && (chk_sum[ADDR_W-1:0] <= r0e_q)) ||
                    (rv1 && (addr_q >= r1s_q) && (chk_sum[ADDR_W-1:0] <= r1e_q)));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    size_d     = size_q;
    amask_d    = amask_q;
    addr_d     = addr_q;
    rlen_d     = rlen_q;
    gnt_d      = gnt_q;
    status_d   = status_q;
    safe_d     = safe_q;
    node_d     = node_q;
    region_d   = region_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    cur_idx_d  = cur_idx_q;
    prev_idx_d = prev_idx_q;
    new_d      = new_q;
    prev_v_d   = prev_v_q;
    aligned_d  = aligned_q;
    pad_d      = pad_q;
    rem_d      = rem_q;
    too_big_d  = too_big_q;
    pop_tail_d = pop_tail_q;
    fresh_d    = fresh_q;
    sp_d       = sp_q;
    built_d    = built_q;
    first0_d   = first0_q;
    first1_d   = first1_q;
    mem_we     = 1'b0;
    mem_waddr  = cur_idx_q;
    mem_wdata  = cur_q;
    mem_raddr  = node_q[NODE_W-1:0];
    push_we    = 1'b0;
    push_idx   = cur_idx_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = cmd_e'(cmd_i);
          size_d   = request_size_i;
          amask_d  = align_mask(request_alignment_i);
          addr_d   = target_address_i;
          rlen_d   = range_length_i;
          gnt_d    = '0;
          status_d = ST_OK;
          safe_d   = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              if (request_size_i == '0) begin
                status_d = ST_BAD_REQ;
                state_d  = S_DONE;
              end else begin
                state_d = built_q ? S_WINIT : S_BUILD0;
              end
            end
            CMD_RELEASE: begin
              if (target_address_i == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = built_q ? S_WINIT : S_BUILD0;
              end
            end
            CMD_CHECK: state_d = S_CHECK;
            default: begin
              status_d = ST_BAD_REQ;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_CHECK: begin
        safe_d  = chk_ok;
        state_d = S_DONE;
      end
      S_BUILD0: begin
        first0_d = NONE_LINK;
        if (rv0) begin
          mem_we    = 1'b1;
          mem_waddr = NODE_W'(fresh_q - LINK_W'(1));
          mem_wdata = '{base: r0s_q, len: r0e_q - r0s_q, free: 1'b1, link: NONE_LINK};
          first0_d  = fresh_q - LINK_W'(1);
          fresh_d   = fresh_q - LINK_W'(1);
        end
        state_d = S_BUILD1;
      end
      S_BUILD1: begin
        first1_d = NONE_LINK;
        if (rv1) begin
          mem_we    = 1'b1;
          mem_waddr = NODE_W'(fresh_q - LINK_W'(1));
          mem_wdata = '{base: r1s_q, len: r1e_q - r1s_q, free: 1'b1, link: NONE_LINK};
          first1_d  = fresh_q - LINK_W'(1);
          fresh_d   = fresh_q - LINK_W'(1);
        end
        built_d = 1'b1;
        state_d = S_WINIT;
      end
      S_WINIT: begin
        region_d = 1'b0;
        prev_v_d = 1'b0;
        node_d   = walk0;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (node_q[NODE_W]) begin
          if (!region_q) begin
            region_d = 1'b1;
            prev_v_d = 1'b0;
            node_d   = walk1;
          end else begin
            gnt_d    = '0;
            status_d = (cmd_q == CMD_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
            state_d  = S_DONE;
          end
        end else begin
          mem_raddr = node_q[NODE_W-1:0];
          cur_idx_d = node_q[NODE_W-1:0];
          state_d   = (cmd_q == CMD_ALLOC) ? S_AEV1 : S_REV;
        end
      end
      S_AEV1: begin
        cur_d     = mem_rdata;
        aligned_d = (mem_rdata.base + amask_q) & ~amask_q;
        if (!mem_rdata.free) begin
          node_d  = mem_rdata.link;
          state_d = S_WALK;
        end else begin
          state_d = S_AEV2;
        end
      end
      S_AEV2: begin
        pad_d   = aligned_q - cur_q.base;
        state_d = S_AFIT;
      end
      S_AFIT: begin
        too_big_d = pad_q > cur_q.len;
        rem_d     = cur_q.len - pad_q;
        state_d   = S_AFIT2;
      end
      S_AFIT2: begin
        node_d = cur_q.link;
        if (too_big_q || (rem_q < size_q)) begin
          state_d = S_WALK;
        end else if (pad_q != '0) begin
          if (!avail) begin
            state_d = S_WALK;
          end else begin
            pop_tail_d = 1'b0;
            state_d    = S_POP;
          end
        end else begin
          state_d = S_TAILCHK;
        end
      end
      S_POP: begin
        if (fresh_q != '0) begin
          new_d   = NODE_W'(fresh_q - LINK_W'(1));
          fresh_d = fresh_q - LINK_W'(1);
          state_d = pop_tail_q ? S_TAILW1 : S_PADW1;
        end else begin
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        new_d   = stack_rd_q;
        sp_d    = sp_m1;
        state_d = pop_tail_q ? S_TAILW1 : S_PADW1;
      end
      S_PADW1: begin
        mem_we    = 1'b1;
        mem_waddr = new_q;
        mem_wdata = '{base: aligned_q, len: rem_q, free: 1'b1, link: cur_q.link};
        state_d   = S_PADW2;
      end
      S_PADW2: begin
        mem_we     = 1'b1;
        mem_waddr  = cur_idx_q;
        mem_wdata  = '{base: cur_q.base, len: pad_q, free: 1'b1, link: {1'b0, new_q}};
        // carry on with the aligned part; a failed tail split resumes the walk here
        cur_idx_d  = new_q;
        cur_d.base = aligned_q;
        cur_d.len  = rem_q;
        node_d     = {1'b0, new_q};
        state_d    = S_TAILCHK;
      end
      S_TAILCHK: begin
        if (cur_q.len > size_q) begin
          if (!avail) begin
            state_d = S_WALK;
          end else begin
            pop_tail_d = 1'b1;
            state_d    = S_POP;
          end
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = cur_idx_q;
          mem_wdata      = cur_q;
          mem_wdata.free = 1'b0;
          gnt_d          = cur_q.base;
          state_d        = S_DONE;
        end
      end
      S_TAILW1: begin
        mem_we    = 1'b1;
        mem_waddr = new_q;
        mem_wdata = '{base: cur_q.base + size_q, len: cur_q.len - size_q, free: 1'b1,
                      link: cur_q.link};
        state_d   = S_TAILW2;
      end
      S_TAILW2: begin
        mem_we    = 1'b1;
        mem_waddr = cur_idx_q;
        mem_wdata = '{base: cur_q.base, len: size_q, free: 1'b0, link: {1'b0, new_q}};
        gnt_d     = cur_q.base;
        state_d   = S_DONE;
      end
      S_REV: begin
        if (mem_rdata.base == addr_q) begin
          if (mem_rdata.free) begin
            status_d = ST_DOUBLE_FREE;
            state_d  = S_DONE;
          end else begin
            cur_d      = mem_rdata;
            cur_d.free = 1'b1;
            state_d    = S_MFRD;
          end
        end else begin
          prev_d     = mem_rdata;
          prev_idx_d = cur_idx_q;
          prev_v_d   = 1'b1;
          node_d     = mem_rdata.link;
          state_d    = S_WALK;
        end
      end
      S_MFRD: begin
        if (cur_q.link[NODE_W]) begin
          state_d = S_MFEND;
        end else begin
          mem_raddr = cur_q.link[NODE_W-1:0];
          state_d   = S_MFEV;
        end
      end
      S_MFEV: begin
        if (mem_rdata.free && ((cur_q.base + cur_q.len) == mem_rdata.base)) begin
          // absorb the next block and recycle its node
          cur_d.len  = cur_q.len + mem_rdata.len;
          cur_d.link = mem_rdata.link;
          push_we    = 1'b1;
          push_idx   = cur_q.link[NODE_W-1:0];
          sp_d       = sp_q + LINK_W'(1);
          state_d    = S_MFRD;
        end else begin
          state_d = S_MFEND;
        end
      end
      S_MFEND: begin
        mem_we = 1'b1;
        if (prev_v_q && prev_q.free && ((prev_q.base + prev_q.len) == cur_q.base)) begin
          mem_waddr = prev_idx_q;
          mem_wdata = '{base: prev_q.base, len: prev_q.len + cur_q.len, free: prev_q.free,
                        link: cur_q.link};
          push_we   = 1'b1;
          push_idx  = cur_idx_q;
          sp_d      = sp_q + LINK_W'(1);
        end else begin
          mem_waddr = cur_idx_q;
          mem_wdata = cur_q;
        end
        status_d = ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      node_q     <= NONE_LINK;
      region_q   <= 1'b0;
      prev_v_q   <= 1'b0;
      pop_tail_q <= 1'b0;
      fresh_q    <= LINK_W'(NODES);
      sp_q       <= '0;
      built_q    <= 1'b0;
      first0_q   <= NONE_LINK;
      first1_q   <= NONE_LINK;
      cmd_q      <= CMD_ALLOC;
      status_q   <= ST_OK;
      safe_q     <= 1'b0;
      gnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      node_q     <= node_d;
      region_q   <= region_d;
      prev_v_q   <= prev_v_d;
      pop_tail_q <= pop_tail_d;
      fresh_q    <= fresh_d;
      sp_q       <= sp_d;
      built_q    <= built_d;
      first0_q   <= first0_d;
      first1_q   <= first1_d;
      cmd_q      <= cmd_d;
      status_q   <= status_d;
      safe_q     <= safe_d;
      gnt_q      <= gnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    amask_q    <= amask_d;
    addr_q     <= addr_d;
    rlen_q     <= rlen_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    cur_idx_q  <= cur_idx_d;
    prev_idx_q <= prev_idx_d;
    new_q      <= new_d;
    aligned_q  <= aligned_d;
    pad_q      <= pad_d;
    rem_q      <= rem_d;
    too_big_q  <= too_big_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign granted_address_o = gnt_q;
  assign status_o          = status_q;
  assign range_safe_o      = safe_q;

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");

  a_node_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, fresh_q} + {1'b0, sp_q}) <= (LINK_W + 1)'(NODES)))
    else $error("spare node count exceeds pool");

  a_safe_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_safe_o) |-> (status_o == ST_OK && granted_address_o == '0))
    else $error("safe check result with non-ok status");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && granted_address_o != '0) |-> (status_o == ST_OK))
    else $error("address granted with failing status");
`endif

endmodule
